>>> rtl/core/rrcs_pkg.sv
// Shared types, codes and helper functions for the round-robin CPU/IO scheduler.
// Used by the top level, rrcs_job_mem, rrcs_queue and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rrcs_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int MAX_BURSTS = 16;
  localparam int JOB_W      = $clog2(MAX_JOBS);
  localparam int POS_W      = $clog2(MAX_BURSTS);
  localparam int TOTAL_W    = POS_W + 1;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int LEN_W      = 16;
  localparam int BADDR_W    = JOB_W + POS_W;
  localparam int QCNT_W     = JOB_W + 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 184;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [LEN_W-1:0]  QUANTUM_RESET = LEN_W'(4);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    K_LOADED     = 4'd0,
    K_ERROR      = 4'd1,
    K_ARRIVED    = 4'd2,
    K_TERMINATED = 4'd3,
    K_IO_BLOCKED = 4'd4,
    K_IO_DONE    = 4'd5,
    K_PREEMPTED  = 4'd6,
    K_CPU_DISP   = 4'd7,
    K_IO_DISP    = 4'd8,
    K_TICK_DONE  = 4'd9,
    K_STATS      = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    PH_UNLOADED = 3'd0,
    PH_LOADING  = 3'd1,
    PH_NEW      = 3'd2,
    PH_READY    = 3'd3,
    PH_RUNNING  = 3'd4,
    PH_BLOCKED  = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    PK_TERM    = 2'd0,
    PK_IOREQ   = 2'd1,
    PK_PREEMPT = 2'd2
  } pend_t;

  typedef struct packed {
    phase_t              phase;
    logic [POS_W-1:0]    pos;
    logic [TOTAL_W-1:0]  total;
    logic [TIME_W-1:0]   arrival;
    logic [CNT_W-1:0]    ready_wait;
    logic [CNT_W-1:0]    io_wait;
    logic [CNT_W-1:0]    turnaround;
  } job_rec_t;

  localparam int REC_W = $bits(job_rec_t);

  function automatic logic [TIME_W-1:0] add_time(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/round_robin_cpu_io_scheduler.sv
// Top level of the round-robin CPU/IO scheduler: sequencer, CPU and IO slots.
// Depends on rrcs_pkg, rrcs_ram, rrcs_job_mem and rrcs_queue.
`timescale 1ns / 1ps
`default_nettype none
// One input beat is taken at a time. A load, arrive or read gives a single result beat
// for each input beat. A tick reports each completion, CPU release and dispatch, and it
// tallies every job waiting in the ready or IO queue, each tally being a read-modify-write
// of the per-job record memory. With 16 jobs at most 15 jobs wait. A result beat that
// finds the output register still full waits for it to drain. Burst lengths live in a
// 256-entry RAM.
module round_robin_cpu_io_scheduler
  import rrcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LEN_W-1:0]      cfg_wr_data,    // quantum
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,        // job_id, burst_length, zero pad
  input  wire logic [1:0]            s_tuser,        // operation
  input  wire logic                  s_tlast,        // final_burst
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,        // result_job, burst_now, wait_ticks,
                                                     // io_wait_ticks, turnaround,
                                                     // current_time, idle_ticks, zero pad
  output logic [3:0]                 m_tuser,        // kind
  output logic                       m_tlast         // last
);

  typedef enum logic [4:0] {
    S_IDLE, S_OP_RD, S_EMIT,
    T_TERM, T_TERM_M, T_IO, T_IO_M, T_CPU, T_CPU_M,
    T_DSP, T_DSP_B, T_DSP_M, T_IOD, T_IOD_B, T_IOD_M,
    T_RW, T_RW_M, T_IW, T_IW_M, T_FIN
  } state_t;

  state_t             state;
  state_t             ret;
  op_t                op;
  logic [JOB_W-1:0]   in_id;
  logic [LEN_W-1:0]   in_len;
  logic               in_fin;
  logic [LEN_W-1:0]   quantum;
  logic [LEN_W-1:0]   q_eff;

  logic               cpu_busy;
  logic [JOB_W-1:0]   cpu_owner;
  logic [TIME_W-1:0]  cpu_deadline;
  pend_t              cpu_pend;
  logic               io_busy;
  logic [JOB_W-1:0]   io_owner;
  logic [TIME_W-1:0]  io_deadline;
  logic [TIME_W-1:0]  tick_count;
  logic [CNT_W-1:0]   idle_count;

  job_rec_t           rec;
  job_rec_t           rec_next;
  logic [JOB_W-1:0]   cur_job;
  logic [QCNT_W-1:0]  idx;

  kind_t              e_kind;
  logic [JOB_W-1:0]   e_job;
  logic [LEN_W-1:0]   e_burst;
  logic               e_tal;
  logic               e_last;

  logic               jm_wr_en;
  logic [JOB_W-1:0]   jm_wr_addr;
  logic               jm_rd_en;
  logic [JOB_W-1:0]   jm_rd_addr;
  job_rec_t           jm_rd_data;

  logic               bm_wr_en;
  logic [BADDR_W-1:0] bm_wr_addr;
  logic [LEN_W-1:0]   bm_wr_data;
  logic               bm_rd_en;
  logic [BADDR_W-1:0] bm_rd_addr;
  logic [LEN_W-1:0]   bm_rd_data;

  logic               rq_push;
  logic [JOB_W-1:0]   rq_push_id;
  logic               rq_pop;
  logic [JOB_W-1:0]   rq_head;
  logic [JOB_W-1:0]   rq_peek;
  logic [QCNT_W-1:0]  rq_count;
  logic               iq_push;
  logic               iq_pop;
  logic [JOB_W-1:0]   iq_head;
  logic [JOB_W-1:0]   iq_peek;
  logic [QCNT_W-1:0]  iq_count;

  logic               load_ok;
  logic               cpu_due;
  logic               io_due;
  logic               out_free;

  rrcs_ram #(.DATA_W(LEN_W), .ADDR_W(BADDR_W)) u_burst (
    .clk(clk), .wr_en(bm_wr_en), .wr_addr(bm_wr_addr), .wr_data(bm_wr_data),
    .rd_en(bm_rd_en), .rd_addr(bm_rd_addr), .rd_data(bm_rd_data)
  );

  rrcs_job_mem u_jobs (
    .clk(clk), .rst(rst), .wr_en(jm_wr_en), .wr_addr(jm_wr_addr), .wr_data(rec_next),
    .rd_en(jm_rd_en), .rd_addr(jm_rd_addr), .rd_data(jm_rd_data)
  );

  rrcs_queue u_ready_q (
    .clk(clk), .rst(rst), .push(rq_push), .push_id(rq_push_id), .pop(rq_pop),
    .peek_ofs(idx[JOB_W-1:0]), .head_id(rq_head), .peek_id(rq_peek), .count(rq_count)
  );

  rrcs_queue u_io_q (
    .clk(clk), .rst(rst), .push(iq_push), .push_id(cur_job), .pop(iq_pop),
    .peek_ofs(idx[JOB_W-1:0]), .head_id(iq_head), .peek_id(iq_peek), .count(iq_count)
  );

  assign q_eff    = (quantum == '0) ? LEN_W'(1) : quantum;
  assign cpu_due  = cpu_busy && (cpu_deadline <= tick_count);
  assign io_due   = io_busy && (io_deadline <= tick_count);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign load_ok  = (in_len != '0) && (jm_rd_data.phase <= PH_LOADING)
                    && (jm_rd_data.total < TOTAL_W'(MAX_BURSTS))
                    && !(in_fin && jm_rd_data.total[0]);

  always_comb begin
    rec_next   = rec;
    jm_wr_en   = 1'b0;
    jm_wr_addr = cur_job;
    jm_rd_en   = 1'b0;
    jm_rd_addr = cur_job;
    bm_wr_en   = 1'b0;
    bm_wr_addr = {in_id, jm_rd_data.total[POS_W-1:0]};
    bm_wr_data = in_len;
    bm_rd_en   = 1'b0;
    bm_rd_addr = {cur_job, jm_rd_data.pos};
    rq_push    = 1'b0;
    rq_push_id = cur_job;
    rq_pop     = 1'b0;
    iq_push    = 1'b0;
    iq_pop     = 1'b0;
    case (state)
      S_IDLE: begin
        jm_rd_addr = s_tdata[JOB_W-1:0];
        jm_rd_en   = s_tvalid && (op_t'(s_tuser) != OP_TICK);
      end
      S_OP_RD: begin
        rec_next   = jm_rd_data;
        jm_wr_addr = in_id;
        if (op == OP_LOAD && load_ok) begin
          rec_next.total = jm_rd_data.total + TOTAL_W'(1);
          rec_next.phase = in_fin ? PH_NEW : PH_LOADING;
          jm_wr_en       = 1'b1;
          bm_wr_en       = 1'b1;
        end else if (op == OP_ARRIVE && jm_rd_data.phase == PH_NEW) begin
          rec_next.phase   = PH_READY;
          rec_next.arrival = tick_count;
          jm_wr_en         = 1'b1;
          rq_push          = 1'b1;
          rq_push_id       = in_id;
        end
      end
      T_TERM: begin
        jm_rd_addr = cpu_owner;
        jm_rd_en   = cpu_due && cpu_pend == PK_TERM;
      end
      T_TERM_M: begin
        rec_next            = jm_rd_data;
        rec_next.phase      = PH_DONE;
        rec_next.turnaround = CNT_W'(tick_count - jm_rd_data.arrival);
        jm_wr_en            = 1'b1;
      end
      T_IO: begin
        jm_rd_addr = io_owner;
        jm_rd_en   = io_due;
      end
      T_IO_M: begin
        rec_next       = jm_rd_data;
        rec_next.phase = PH_READY;
        rec_next.pos   = jm_rd_data.pos + POS_W'(1);
        jm_wr_en       = 1'b1;
        rq_push        = 1'b1;
      end
      T_CPU: begin
        jm_rd_addr = cpu_owner;
        jm_rd_en   = cpu_due && cpu_pend != PK_TERM;
      end
      T_CPU_M: begin
        rec_next = jm_rd_data;
        jm_wr_en = 1'b1;
        if (cpu_pend == PK_IOREQ) begin
          rec_next.phase = PH_BLOCKED;
          rec_next.pos   = jm_rd_data.pos + POS_W'(1);
          iq_push        = 1'b1;
        end else begin
          rec_next.phase = PH_READY;
          rq_push        = 1'b1;
        end
      end
      T_DSP: begin
        jm_rd_addr = rq_head;
        jm_rd_en   = !cpu_busy && rq_count != '0;
        rq_pop     = jm_rd_en;
      end
      T_DSP_B, T_IOD_B: begin
        bm_rd_en = 1'b1;
      end
      T_DSP_M: begin
        rec_next.phase = PH_RUNNING;
        jm_wr_en       = 1'b1;
        bm_wr_addr     = {cur_job, rec.pos};
        bm_wr_data     = bm_rd_data - q_eff;
        bm_wr_en       = bm_rd_data > q_eff;
      end
      T_IOD: begin
        jm_rd_addr = iq_head;
        jm_rd_en   = !io_busy && iq_count != '0;
        iq_pop     = jm_rd_en;
      end
      T_RW: begin
        jm_rd_addr = rq_peek;
        jm_rd_en   = idx < rq_count;
      end
      T_RW_M: begin
        rec_next            = jm_rd_data;
        rec_next.ready_wait = sat_inc(jm_rd_data.ready_wait);
        jm_wr_en            = 1'b1;
      end
      T_IW: begin
        jm_rd_addr = iq_peek;
        jm_rd_en   = idx < iq_count;
      end
      T_IW_M: begin
        rec_next         = jm_rd_data;
        rec_next.io_wait = sat_inc(jm_rd_data.io_wait);
        jm_wr_en         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      quantum      <= QUANTUM_RESET;
      cpu_busy     <= 1'b0;
      cpu_pend     <= PK_TERM;
      cpu_deadline <= '0;
      io_busy      <= 1'b0;
      io_deadline  <= '0;
      tick_count   <= '0;
      idle_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        quantum <= cfg_wr_data;
      end
      if (m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= op_t'(s_tuser);
            in_id   <= s_tdata[JOB_W-1:0];
            in_len  <= s_tdata[JOB_W +: LEN_W];
            in_fin  <= s_tlast;
            cur_job <= s_tdata[JOB_W-1:0];
            state   <= (op_t'(s_tuser) == OP_TICK) ? T_TERM : S_OP_RD;
          end
        end
        S_OP_RD: begin
          rec     <= rec_next;
          e_job   <= in_id;
          e_last  <= 1'b1;
          ret     <= S_IDLE;
          state   <= S_EMIT;
          case (op)
            OP_LOAD: begin
              e_kind  <= load_ok ? K_LOADED : K_ERROR;
              e_burst <= load_ok ? in_len : LEN_W'(0);
              e_tal   <= 1'b0;
            end
            OP_ARRIVE: begin
              e_kind  <= (jm_rd_data.phase == PH_NEW) ? K_ARRIVED : K_ERROR;
              e_burst <= '0;
              e_tal   <= (jm_rd_data.phase == PH_NEW);
            end
            OP_READ: begin
              e_kind  <= K_STATS;
              e_burst <= '0;
              e_tal   <= 1'b1;
            end
            default: begin
              e_kind  <= K_ERROR;
              e_burst <= '0;
              e_tal   <= 1'b0;
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= e_kind;
            m_tlast  <= e_last;
            m_tdata  <= {4'b0, idle_count, tick_count[31:0],
                         e_tal ? rec.turnaround : CNT_W'(0),
                         e_tal ? rec.io_wait : CNT_W'(0),
                         e_tal ? rec.ready_wait : CNT_W'(0),
                         e_burst, e_job};
            state    <= ret;
          end
        end
        T_TERM: begin
          cur_job <= cpu_owner;
          state   <= (cpu_due && cpu_pend == PK_TERM) ? T_TERM_M : T_IO;
        end
        T_TERM_M: begin
          rec      <= rec_next;
          cpu_busy <= 1'b0;
          e_job    <= cur_job;
          e_kind   <= K_TERMINATED;
          e_burst  <= '0;
          e_tal    <= 1'b1;
          e_last   <= 1'b0;
          ret      <= T_IO;
          state    <= S_EMIT;
        end
        T_IO: begin
          cur_job <= io_owner;
          state   <= io_due ? T_IO_M : T_CPU;
        end
        T_IO_M: begin
          rec     <= rec_next;
          io_busy <= 1'b0;
          e_job   <= cur_job;
          e_kind  <= K_IO_DONE;
          e_burst <= '0;
          e_tal   <= 1'b1;
          e_last  <= 1'b0;
          ret     <= T_CPU;
          state   <= S_EMIT;
        end
        T_CPU: begin
          cur_job <= cpu_owner;
          state   <= (cpu_due && cpu_pend != PK_TERM) ? T_CPU_M : T_DSP;
        end
        T_CPU_M: begin
          rec      <= rec_next;
          cpu_busy <= 1'b0;
          e_job    <= cur_job;
          e_kind   <= (cpu_pend == PK_IOREQ) ? K_IO_BLOCKED : K_PREEMPTED;
          e_burst  <= '0;
          e_tal    <= 1'b1;
          e_last   <= 1'b0;
          ret      <= T_DSP;
          state    <= S_EMIT;
        end
        T_DSP: begin
          cur_job <= rq_head;
          state   <= (!cpu_busy && rq_count != '0) ? T_DSP_B : T_IOD;
        end
        T_DSP_B: begin
          rec   <= jm_rd_data;
          state <= T_DSP_M;
        end
        T_DSP_M: begin
          rec       <= rec_next;
          cpu_busy  <= 1'b1;
          cpu_owner <= cur_job;
          if (bm_rd_data > q_eff) begin
            cpu_pend     <= PK_PREEMPT;
            cpu_deadline <= add_time(tick_count, TIME_W'(q_eff));
          end else begin
            cpu_pend     <= (({1'b0, rec.pos} + TOTAL_W'(1)) >= rec.total) ? PK_TERM
                                                                          : PK_IOREQ;
            cpu_deadline <= add_time(tick_count, TIME_W'(bm_rd_data));
          end
          e_job   <= cur_job;
          e_kind  <= K_CPU_DISP;
          e_burst <= bm_rd_data;
          e_tal   <= 1'b1;
          e_last  <= 1'b0;
          ret     <= T_IOD;
          state   <= S_EMIT;
        end
        T_IOD: begin
          cur_job <= iq_head;
          idx     <= '0;
          state   <= (!io_busy && iq_count != '0) ? T_IOD_B : T_RW;
        end
        T_IOD_B: begin
          rec   <= jm_rd_data;
          state <= T_IOD_M;
        end
        T_IOD_M: begin
          io_busy     <= 1'b1;
          io_owner    <= cur_job;
          io_deadline <= add_time(tick_count, TIME_W'(bm_rd_data));
          e_job       <= cur_job;
          e_kind      <= K_IO_DISP;
          e_burst     <= bm_rd_data;
          e_tal       <= 1'b1;
          e_last      <= 1'b0;
          ret         <= T_RW;
          state       <= S_EMIT;
        end
        T_RW: begin
          cur_job <= rq_peek;
          if (idx < rq_count) begin
            state <= T_RW_M;
          end else begin
            idx   <= '0;
            state <= T_IW;
          end
        end
        T_RW_M: begin
          idx   <= idx + QCNT_W'(1);
          state <= T_RW;
        end
        T_IW: begin
          cur_job <= iq_peek;
          state   <= (idx < iq_count) ? T_IW_M : T_FIN;
        end
        T_IW_M: begin
          idx   <= idx + QCNT_W'(1);
          state <= T_IW;
        end
        T_FIN: begin
          if (!cpu_busy) begin
            idle_count <= sat_inc(idle_count);
          end
          tick_count <= add_time(tick_count, TIME_W'(1));
          e_job      <= '0;
          e_kind     <= K_TICK_DONE;
          e_burst    <= '0;
          e_tal      <= 1'b0;
          e_last     <= 1'b1;
          ret        <= S_IDLE;
          state      <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rrcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; holds the burst lengths of all jobs.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rrcs_job_mem.sv
// Per-job record memory with a valid bit per entry so that reset reads as zero.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_job_mem
  import rrcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [JOB_W-1:0] wr_addr,
  input  wire job_rec_t         wr_data,
  input  wire logic             rd_en,
  input  wire logic [JOB_W-1:0] rd_addr,
  output job_rec_t              rd_data
);

  job_rec_t              mem [MAX_JOBS];
  logic [MAX_JOBS-1:0]   valid;
  job_rec_t              rd_q;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : job_rec_t'('0);

endmodule
`default_nettype wire

>>> rtl/core/rrcs_queue.sv
// Circular job queue with push, pop and a peek port for walking its entries.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_queue
  import rrcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [JOB_W-1:0]  push_id,
  input  wire logic              pop,
  input  wire logic [JOB_W-1:0]  peek_ofs,
  output logic      [JOB_W-1:0]  head_id,
  output logic      [JOB_W-1:0]  peek_id,
  output logic      [QCNT_W-1:0] count
);

  logic [JOB_W-1:0] slot [MAX_JOBS];
  logic [JOB_W-1:0] head;
  logic [JOB_W-1:0] tail;

  assign tail    = head + count[JOB_W-1:0];
  assign head_id = slot[head];
  assign peek_id = slot[head + peek_ofs];

  always_ff @(posedge clk) begin
    if (push && count != QCNT_W'(MAX_JOBS)) begin
      slot[tail] <= push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (push && count != QCNT_W'(MAX_JOBS)) begin
      count <= count + QCNT_W'(1);
    end else if (pop && count != '0) begin
      head  <= head + JOB_W'(1);
      count <= count - QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for round_robin_cpu_io_scheduler: directed table, then random jobs.
// Predicts every result beat with an in-bench scheduler model; depends on rrcs_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import rrcs_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  job;
    logic [15:0] burst;
    logic [31:0] rwait;
    logic [31:0] iowait;
    logic [31:0] turn;
    logic [31:0] now;
    logic [31:0] idle;
    logic        lastb;
  } sched_ev_t;

  typedef struct {
    op_t         op;
    logic [3:0]  job;
    logic [15:0] len;
    logic        fin;
    logic        has_known;
    kind_t       known_kind;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [3:0] m_tuser;
  logic m_tlast;

  round_robin_cpu_io_scheduler i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // Scheduler state mirrored in the bench.
  logic [15:0] quantum_q;
  phase_t      phase_q [16];
  logic [15:0] bursts_q [256];
  logic [3:0]  pos_q [16];
  logic [4:0]  total_q [16];
  logic [31:0] arrive_q [16];
  logic [31:0] rwait_q [16];
  logic [31:0] iowait_q [16];
  logic [31:0] turn_q [16];
  logic [3:0]  ready_q [$];
  logic [3:0]  io_q [$];
  logic        cpu_busy, io_busy;
  logic [3:0]  cpu_job, io_job;
  logic [31:0] cpu_due, io_due;
  pend_t       cpu_pend;
  logic [31:0] now_q, idle_q;

  sched_ev_t expected_beats [$];
  int mismatches = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit gen_done = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  task automatic note_beat(kind_t k, logic [3:0] j, logic [15:0] b, bit tallies);
    sched_ev_t e;
    e.kind = k; e.job = j; e.burst = b;
    e.rwait = tallies ? rwait_q[j] : '0;
    e.iowait = tallies ? iowait_q[j] : '0;
    e.turn = tallies ? turn_q[j] : '0;
    e.now = now_q; e.idle = idle_q; e.lastb = 1'b0;
    expected_beats.insert(expected_beats.size(), e);
  endtask

  task automatic clear_schedule();
    quantum_q = QUANTUM_RESET;
    for (int i = 0; i < 16; i++) begin
      phase_q[i] = PH_UNLOADED; pos_q[i] = '0; total_q[i] = '0; arrive_q[i] = '0;
      rwait_q[i] = '0; iowait_q[i] = '0; turn_q[i] = '0;
    end
    ready_q.delete(); io_q.delete();
    cpu_busy = 0; io_busy = 0; cpu_job = '0; io_job = '0;
    cpu_due = '0; io_due = '0; cpu_pend = PK_TERM; now_q = '0; idle_q = '0;
  endtask

  task automatic advance_tick();
    logic [31:0] q;
    logic [15:0] rem;
    logic [7:0] a;
    logic [3:0] j;
    q = (quantum_q == 0) ? 32'd1 : {16'd0, quantum_q};
    if (cpu_busy && cpu_pend == PK_TERM && cpu_due <= now_q) begin
      j = cpu_job;
      phase_q[j] = PH_DONE;
      turn_q[j] = now_q - arrive_q[j];
      cpu_busy = 0;
      note_beat(K_TERMINATED, j, '0, 1);
    end
    if (io_busy && io_due <= now_q) begin
      j = io_job;
      phase_q[j] = PH_READY; pos_q[j] = pos_q[j] + 1'b1;
      ready_q.insert(ready_q.size(), j); io_busy = 0;
      note_beat(K_IO_DONE, j, '0, 1);
    end
    if (cpu_busy && cpu_pend != PK_TERM && cpu_due <= now_q) begin
      j = cpu_job;
      if (cpu_pend == PK_IOREQ) begin
        phase_q[j] = PH_BLOCKED; pos_q[j] = pos_q[j] + 1'b1;
        io_q.insert(io_q.size(), j);
        note_beat(K_IO_BLOCKED, j, '0, 1);
      end else begin
        phase_q[j] = PH_READY; ready_q.insert(ready_q.size(), j);
        note_beat(K_PREEMPTED, j, '0, 1);
      end
      cpu_busy = 0;
    end
    if (!cpu_busy && ready_q.size() > 0) begin
      j = ready_q[0];
      ready_q.delete(0);
      cpu_job = j; cpu_busy = 1; phase_q[j] = PH_RUNNING;
      a = {j, pos_q[j]};
      rem = bursts_q[a];
      if ({16'd0, rem} > q) begin
        cpu_pend = PK_PREEMPT; cpu_due = sat_add(now_q, q);
        bursts_q[a] = rem - q[15:0];
      end else begin
        cpu_pend = ({1'b0, pos_q[j]} + 5'd1 >= total_q[j]) ? PK_TERM : PK_IOREQ;
        cpu_due = sat_add(now_q, {16'd0, rem});
      end
      note_beat(K_CPU_DISP, j, rem, 1);
    end
    if (!io_busy && io_q.size() > 0) begin
      j = io_q[0];
      io_q.delete(0);
      io_job = j; io_busy = 1;
      rem = bursts_q[{j, pos_q[j]}];
      io_due = sat_add(now_q, {16'd0, rem});
      note_beat(K_IO_DISP, j, rem, 1);
    end
    foreach (ready_q[i]) rwait_q[ready_q[i]] = bump(rwait_q[ready_q[i]]);
    foreach (io_q[i]) iowait_q[io_q[i]] = bump(iowait_q[io_q[i]]);
    if (!cpu_busy) idle_q = bump(idle_q);
    now_q = bump(now_q);
    note_beat(K_TICK_DONE, '0, '0, 0);
  endtask

  task automatic predict_item(op_t op, logic [3:0] j, logic [15:0] len, logic fin);
    logic [4:0] t;
    case (op)
      OP_TICK: advance_tick();
      OP_LOAD: begin
        t = total_q[j];
        if (len != 0 && phase_q[j] <= PH_LOADING && t < 16 && !(fin && t[0])) begin
          bursts_q[{j, t[3:0]}] = len;
          total_q[j] = t + 1'b1;
          phase_q[j] = fin ? PH_NEW : PH_LOADING;
          note_beat(K_LOADED, j, len, 0);
        end else begin
          note_beat(K_ERROR, j, '0, 0);
        end
      end
      OP_ARRIVE: begin
        if (phase_q[j] == PH_NEW) begin
          phase_q[j] = PH_READY; arrive_q[j] = now_q; ready_q.insert(ready_q.size(), j);
          note_beat(K_ARRIVED, j, '0, 1);
        end else begin
          note_beat(K_ERROR, j, '0, 0);
        end
      end
      default: note_beat(K_STATS, j, '0, 1);
    endcase
    expected_beats[$].lastb = 1'b1;
  endtask

  task automatic send_item(op_t op, logic [3:0] j, logic [15:0] len, logic fin, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 6) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    predict_item(op, j, len, fin);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, len, j};
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_quantum(logic [15:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    quantum_q = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Loads a well-formed job with random burst count and lengths, then lets it arrive.
  task automatic run_job(logic [3:0] j, bit gaps);
    int n;
    n = 2 * $urandom_range(7) + 1;
    if ($urandom_range(9) == 0) n = 15;
    for (int b = 0; b < n; b++)
      send_item(OP_LOAD, j,
                ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 9)),
                b == n - 1, gaps);
    send_item(OP_ARRIVE, j, '0, 1'b0, gaps);
  endtask

  stim_row_t dir_rows [] = '{
    '{OP_READ,   4'd0,  16'd0,     1'b0, 1'b1, K_STATS},
    '{OP_ARRIVE, 4'd0,  16'd0,     1'b0, 1'b1, K_ERROR},
    '{OP_LOAD,   4'd0,  16'd0,     1'b0, 1'b1, K_ERROR},
    '{OP_LOAD,   4'd0,  16'd3,     1'b0, 1'b1, K_LOADED},
    '{OP_LOAD,   4'd0,  16'd2,     1'b1, 1'b1, K_ERROR},
    '{OP_ARRIVE, 4'd0,  16'd0,     1'b0, 1'b1, K_ERROR},
    '{OP_LOAD,   4'd0,  16'd2,     1'b0, 1'b1, K_LOADED},
    '{OP_LOAD,   4'd0,  16'd9,     1'b1, 1'b1, K_LOADED},
    '{OP_LOAD,   4'd0,  16'd1,     1'b0, 1'b1, K_ERROR},
    '{OP_LOAD,   4'd15, 16'hFFFF,  1'b1, 1'b1, K_LOADED},
    '{OP_ARRIVE, 4'd0,  16'd0,     1'b0, 1'b1, K_ARRIVED},
    '{OP_ARRIVE, 4'd15, 16'd0,     1'b1, 1'b1, K_ARRIVED},
    '{OP_ARRIVE, 4'd15, 16'd0,     1'b0, 1'b1, K_ERROR},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_READ,   4'd15, 16'd0,     1'b0, 1'b1, K_STATS},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_TICK,   4'd0,  16'd0,     1'b0, 1'b0, K_TICK_DONE},
    '{OP_READ,   4'd0,  16'hFFFF,  1'b1, 1'b1, K_STATS}
  };

  initial begin
    int jobs_left;
    clear_schedule();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].job, dir_rows[i].len, dir_rows[i].fin, 0);
      if (dir_rows[i].has_known && expected_beats[$].kind != dir_rows[i].known_kind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predicted kind %0d", i, expected_beats[$].kind);
      end
    end
    set_quantum(16'd0);
    repeat (40) send_item(OP_TICK, '0, '0, 1'b0, 1);
    // Sender pauses until all results are in; then the receiver hold-off runs.
    wait_drained();
    hold_cycles = 400;
    for (int p = 0; p < 4; p++) begin
      if (p == 1) set_quantum(16'hFFFF);
      if (p == 2) set_quantum(16'd1);
      if (p == 3) set_quantum(16'($urandom_range(2, 6)));
      jobs_left = 0;
      for (int j = 1; j < 15; j++) begin
        if (phase_q[j] <= PH_LOADING && total_q[j] == 0 && jobs_left < 4) begin
          run_job(4'(j), 1); jobs_left++;
        end
      end
      repeat (60) begin
        case ($urandom_range(19))
          0: send_item(OP_READ, 4'($urandom), '0, 1'($urandom), 1);
          1: send_item(OP_LOAD, 4'($urandom), 16'($urandom), 1'($urandom), 1);
          2: send_item(OP_ARRIVE, 4'($urandom), 16'($urandom), 1'b0, 1);
          default: send_item(OP_TICK, 4'($urandom), 16'($urandom), 1'($urandom), 1);
        endcase
      end
    end
    wait_drained();
    gen_done = 1;
  end

  initial begin
    @(negedge clk);
    while (!gen_done) begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= 6) || (cycles > 2000 && cycles < 9000);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    sched_ev_t e;
    sched_ev_t got;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser); got.job = m_tdata[3:0]; got.burst = m_tdata[19:4];
      got.rwait = m_tdata[51:20]; got.iowait = m_tdata[83:52]; got.turn = m_tdata[115:84];
      got.now = m_tdata[147:116]; got.idle = m_tdata[179:148]; got.lastb = m_tlast;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind %0d job %0d", m_tuser, got.job);
      end else begin
        e = expected_beats[0];
        expected_beats.delete(0);
        if (got != e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp k%0d j%0d b%0d w%0d io%0d t%0d now%0d i%0d l%0d",
                     e.kind, e.job, e.burst, e.rwait, e.iowait, e.turn, e.now, e.idle,
                     e.lastb);
            $display("         got k%0d j%0d b%0d w%0d io%0d t%0d now%0d i%0d l%0d",
                     got.kind, got.job, got.burst, got.rwait, got.iowait, got.turn,
                     got.now, got.idle, got.lastb);
          end
        end
      end
    end
  end

  initial begin
    while (!gen_done && cycles < 600000) @(posedge clk);
    if (!gen_done) begin
      $display("end of test: mismatches");
    end else if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rrcs_pkg.sv
rtl/core/rrcs_ram.sv
rtl/core/rrcs_job_mem.sv
rtl/core/rrcs_queue.sv
rtl/core/round_robin_cpu_io_scheduler.sv
sim/tb_top.sv
